// ===== rtl/uart_rx_tx_ring_buffers_top_assert.svh =====
// Assertion macros shared by the checker of the UART ring buffer block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef UART_RX_TX_RING_BUFFERS_TOP_ASSERT_SVH
`define UART_RX_TX_RING_BUFFERS_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define URB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("urb assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define URB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("urb assertion failed");

`endif

// ===== rtl/urb_pkg.sv =====
// Package for the UART receive/transmit ring buffer block.
// Holds operation codes, field widths and the result flag struct; no dependencies.
package urb_pkg;

  localparam int OP_W           = 3;
  localparam int BYTE_W         = 8;
  localparam int COUNT_W        = 7;
  localparam int COUNT_MAX      = 127;
  localparam int RING_DEPTH_DEF = 128;

  typedef enum logic [OP_W-1:0] {
    OP_RX_BYTE  = 3'd0,
    OP_READ     = 3'd1,
    OP_PEEK     = 3'd2,
    OP_COUNT    = 3'd3,
    OP_FLUSH    = 3'd4,
    OP_TX_WRITE = 3'd5,
    OP_TX_READY = 3'd6
  } op_t;

  // Result of one operation, except for the byte itself, which comes from
  // the registered read port of one of the two rings.
  typedef struct packed {
    logic               valid;
    logic               rd_rx;
    logic               rd_tx;
    logic               send;
    logic               irq;
    logic               dropped;
    logic               full;
    logic [COUNT_W-1:0] count;
  } res_flags_t;

endpackage

// ===== rtl/uart_rx_tx_ring_buffers_top.sv =====
// UART receive/transmit ring buffers: one operation per word, one result word each.
// Each result passes through an input register, then the pointer logic and the ring RAM
// read port into the result register. Throughput: one operation per cycle while out_stall
// is low; the ring RAMs take one access per cycle each.
// Reset clears all four ring pointers and the transmit interrupt enable. Ring contents
// are left as they are; nothing reads them before it has been written.
module uart_rx_tx_ring_buffers_top #(
  parameter int RING_DEPTH = urb_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [urb_pkg::OP_W-1:0]      op,
  input  logic [urb_pkg::BYTE_W-1:0]    data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [urb_pkg::BYTE_W-1:0]    byte_out,
  output logic                          byte_valid,
  output logic [urb_pkg::COUNT_W-1:0]   rx_count,
  output logic                          line_send,
  output logic                          tx_irq_enabled,
  output logic                          rx_dropped,
  output logic                          tx_full
);
  import urb_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);

  // Input register: holds the accepted word until the result stage has room.
  logic              in_v;
  logic [OP_W-1:0]   op_q;
  logic [BYTE_W-1:0] data_q;

  // Result register and the read data of both rings, which belong to it.
  logic       out_v;
  res_flags_t out_flags;
  logic       out_free;
  logic       fire;

  logic              rx_we, rx_re, tx_we, tx_re;
  logic [PTR_W-1:0]  rx_waddr, rx_raddr, tx_waddr, tx_raddr;
  logic [BYTE_W-1:0] wdata, rx_rdata, tx_rdata;
  res_flags_t        flags;

  // The result stage frees up when it is empty or its word is taken this cycle.
  // An operation executes, and its ring read is issued, only when it can move on,
  // so the ring read data stays put for as long as the result is stalled.
  assign out_free = !out_v || !out_stall;
  assign fire     = in_v && out_free;
  assign in_stall = in_v && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (!in_stall) begin
      in_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      op_q   <= op;
      data_q <= data_byte;
    end
  end

  urb_ctrl #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .op       (op_q),
    .data     (data_q),
    .rx_we    (rx_we),
    .rx_waddr (rx_waddr),
    .rx_re    (rx_re),
    .rx_raddr (rx_raddr),
    .tx_we    (tx_we),
    .tx_waddr (tx_waddr),
    .tx_re    (tx_re),
    .tx_raddr (tx_raddr),
    .wdata    (wdata),
    .flags    (flags)
  );

  // Receive ring store.
  urb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (wdata),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  // Transmit ring store.
  urb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (wdata),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_free) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_flags <= flags;
    end
  end

  // The byte comes from whichever ring the operation read; otherwise it is zero.
  always_comb begin
    if (out_flags.rd_rx) begin
      byte_out = rx_rdata;
    end else if (out_flags.rd_tx) begin
      byte_out = tx_rdata;
    end else begin
      byte_out = '0;
    end
  end

  assign out_valid      = out_v;
  assign byte_valid     = out_flags.valid;
  assign rx_count       = out_flags.count;
  assign line_send      = out_flags.send;
  assign tx_irq_enabled = out_flags.irq;
  assign rx_dropped     = out_flags.dropped;
  assign tx_full        = out_flags.full;

endmodule

// ===== rtl/urb_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; the read data holds its value while no read is enabled.
module urb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/urb_ctrl.sv =====
// Pointer and interrupt-enable control for the two rings.
// Depends on urb_pkg; drives the write and read ports of both ring RAMs.
module urb_ctrl #(
  parameter int RING_DEPTH = urb_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [urb_pkg::OP_W-1:0]      op,
  input  logic [urb_pkg::BYTE_W-1:0]    data,
  output logic                          rx_we,
  output logic [$clog2(RING_DEPTH)-1:0] rx_waddr,
  output logic                          rx_re,
  output logic [$clog2(RING_DEPTH)-1:0] rx_raddr,
  output logic                          tx_we,
  output logic [$clog2(RING_DEPTH)-1:0] tx_waddr,
  output logic                          tx_re,
  output logic [$clog2(RING_DEPTH)-1:0] tx_raddr,
  output logic [urb_pkg::BYTE_W-1:0]    wdata,
  output urb_pkg::res_flags_t           flags
);
  import urb_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int LVL_W = (PTR_W + 1 > COUNT_W) ? PTR_W + 1 : COUNT_W;

  logic [PTR_W-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [PTR_W-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic             tx_irq_on, tx_irq_on_next;
  logic [PTR_W-1:0] rx_head_inc, rx_tail_inc, tx_head_inc, tx_tail_inc;
  logic [PTR_W:0]   rx_level;
  logic [LVL_W-1:0] rx_level_ext;
  logic [COUNT_W-1:0] rx_count;
  op_t              op_e;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign op_e        = op_t'(op);
  assign rx_head_inc = ptr_inc(rx_head);
  assign rx_tail_inc = ptr_inc(rx_tail);
  assign tx_head_inc = ptr_inc(tx_head);
  assign tx_tail_inc = ptr_inc(tx_tail);

  assign rx_waddr = rx_head;
  assign rx_raddr = rx_tail;
  assign tx_waddr = tx_head;
  assign tx_raddr = tx_tail;
  assign wdata    = data;

  always_comb begin
    rx_head_next   = rx_head;
    rx_tail_next   = rx_tail;
    tx_head_next   = tx_head;
    tx_tail_next   = tx_tail;
    tx_irq_on_next = tx_irq_on;
    rx_we          = 1'b0;
    rx_re          = 1'b0;
    tx_we          = 1'b0;
    tx_re          = 1'b0;
    flags          = '0;
    if (fire) begin
      case (op_e)
        OP_RX_BYTE: begin
          if (rx_head_inc == rx_tail) begin
            flags.dropped = 1'b1;
          end else begin
            rx_we        = 1'b1;
            rx_head_next = rx_head_inc;
          end
        end
        OP_READ, OP_PEEK: begin
          if (rx_head != rx_tail) begin
            rx_re       = 1'b1;
            flags.valid = 1'b1;
            flags.rd_rx = 1'b1;
            if (op_e == OP_READ) begin
              rx_tail_next = rx_tail_inc;
            end
          end
        end
        OP_FLUSH: begin
          rx_head_next = '0;
          rx_tail_next = '0;
        end
        OP_TX_WRITE: begin
          if (tx_head_inc == tx_tail) begin
            flags.full = 1'b1;
          end else begin
            tx_we          = 1'b1;
            tx_head_next   = tx_head_inc;
            tx_irq_on_next = 1'b1;
          end
        end
        OP_TX_READY: begin
          if (tx_irq_on) begin
            if (tx_head == tx_tail) begin
              tx_irq_on_next = 1'b0;
            end else begin
              tx_re        = 1'b1;
              tx_tail_next = tx_tail_inc;
              flags.valid  = 1'b1;
              flags.rd_tx  = 1'b1;
              flags.send   = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    flags.irq   = tx_irq_on_next;
    flags.count = rx_count;
  end

  // Fill level after the operation, saturated to the width of rx_count.
  always_comb begin
    if (rx_head_next >= rx_tail_next) begin
      rx_level = {1'b0, rx_head_next} - {1'b0, rx_tail_next};
    end else begin
      rx_level = {1'b0, rx_head_next} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, rx_tail_next};
    end
    rx_level_ext = LVL_W'(rx_level);
    if (rx_level_ext > LVL_W'(COUNT_MAX)) begin
      rx_count = COUNT_W'(COUNT_MAX);
    end else begin
      rx_count = rx_level_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head   <= '0;
      rx_tail   <= '0;
      tx_head   <= '0;
      tx_tail   <= '0;
      tx_irq_on <= 1'b0;
    end else begin
      rx_head   <= rx_head_next;
      rx_tail   <= rx_tail_next;
      tx_head   <= tx_head_next;
      tx_tail   <= tx_tail_next;
      tx_irq_on <= tx_irq_on_next;
    end
  end

endmodule

// ===== rtl/urb_checker.sv =====
// Port-level checker for the UART ring buffer block, bound to its top level.
// Depends on urb_pkg and the assertion macros in uart_rx_tx_ring_buffers_top_assert.svh.
`include "uart_rx_tx_ring_buffers_top_assert.svh"

module urb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [urb_pkg::OP_W-1:0]    op,
  input logic [urb_pkg::BYTE_W-1:0]  data_byte,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [urb_pkg::BYTE_W-1:0]  byte_out,
  input logic                        byte_valid,
  input logic [urb_pkg::COUNT_W-1:0] rx_count,
  input logic                        line_send,
  input logic                        tx_irq_enabled,
  input logic                        rx_dropped,
  input logic                        tx_full
);
  import urb_pkg::*;

  // A stalled input word stays offered and unchanged.
  `URB_ASSERT_NEXT(a_in_stall_holds, in_valid && in_stall,
                   in_valid && $stable(op) && $stable(data_byte))

  // A byte goes to the line only while the interrupt enable is set.
  `URB_ASSERT_SAME(a_send_needs_irq, out_valid && line_send, byte_valid && tx_irq_enabled)

  // Without a real byte the data word reads as zero.
  `URB_ASSERT_SAME(a_empty_byte_zero, out_valid && !byte_valid, byte_out == '0)

  // A dropped or refused byte never comes with a byte result.
  `URB_ASSERT_SAME(a_reject_no_byte, out_valid && (rx_dropped || tx_full), !byte_valid)

  // A stalled result keeps its byte and its ring level.
  `URB_ASSERT_NEXT(a_stall_holds, out_valid && out_stall,
                   out_valid && $stable(byte_out) && $stable(rx_count))

endmodule

bind uart_rx_tx_ring_buffers_top urb_checker u_urb_checker (.*);
